// ===== rtl/kst_pkg.sv =====
// Shared types and constants for the key slot table.
`timescale 1ns / 1ps
`default_nettype none
package kst_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_GET    = 2'd1,
    REQ_REMOVE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] key;
    logic [15:0] event_mask;
  } kst_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  slot_index;
    logic [15:0] found_mask;
    logic [4:0]  high_water;
  } kst_rsp_t;

  // Request token walking down the cell chain.
  typedef struct packed {
    logic             active;
    logic [1:0]       req;
    logic [15:0]      key;
    logic [15:0]      mask;
    logic             hit;
    logic [IDX_W-1:0] slot;
    logic [15:0]      fmask;
  } kst_tok_t;

endpackage
`default_nettype wire

// ===== rtl/kst_cell.sv =====
// One table slot: stores key, mask and valid, serves the passing token.
`timescale 1ns / 1ps
`default_nettype none
module kst_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic [kst_pkg::IDX_W-1:0] idx_i,
  input  wire kst_pkg::kst_tok_t       tok_i,
  output kst_pkg::kst_tok_t            tok_o
);

  logic              valid_q, valid_d;
  logic [15:0]       key_q, mask_q;
  logic              wr_en;
  kst_pkg::kst_tok_t tok_q, tok_d;

  always_comb begin
    tok_d   = tok_i;
    valid_d = valid_q;
    wr_en   = 1'b0;
    if (tok_i.active && !tok_i.hit) begin
      case (tok_i.req)
        kst_pkg::REQ_ADD: begin
          if (!valid_q) begin
            wr_en     = 1'b1;
            valid_d   = 1'b1;
            tok_d.hit = 1'b1;
            tok_d.slot = idx_i;
          end
        end
        kst_pkg::REQ_GET: begin
          if (valid_q && key_q == tok_i.key) begin
            tok_d.hit   = 1'b1;
            tok_d.slot  = idx_i;
            tok_d.fmask = mask_q;
          end
        end
        kst_pkg::REQ_REMOVE: begin
          if (valid_q && key_q == tok_i.key) begin
            valid_d    = 1'b0;
            tok_d.hit  = 1'b1;
            tok_d.slot = idx_i;
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  // Slot payload, meaningful only while valid.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_q  <= tok_i.key;
      mask_q <= tok_i.mask;
    end
  end

  assign tok_o = tok_q;

endmodule
`default_nettype wire

// ===== rtl/key_slot_table_first_free_core.sv =====
// Top level of the key slot table with first-free allocation.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one request:
//   add, get or remove. Output channel (out_valid_o / out_stall_i /
//   out_data_o) returns exactly one response per request.
//   Each request enters a token that walks a chain of TABLE_DEPTH slot cells,
//   one cell per cycle; the lowest cell that can serve it claims it.
//   The token passes from the entry register through each cell register in
//   order, then into the output register that drives the response.
//   Only one request is in flight; the next input transfer can be taken in
//   the cycle after the response transfer.
//   The high-water mark grows when an add claims the slot at the mark.
//   Reset clears all valid marks and the high-water mark; keys and masks
//   are not cleared.
//   A stalled response is held unchanged in the output register, and
//   in_stall_o stays high until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module key_slot_table_first_free_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire kst_pkg::kst_req_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output kst_pkg::kst_rsp_t      out_data_o
);

  localparam int D = kst_pkg::TABLE_DEPTH;

  logic                      busy_q, busy_d;
  logic                      in_xfer, out_xfer;
  kst_pkg::kst_tok_t         head_q, head_d;
  kst_pkg::kst_tok_t         chain [D+1];
  kst_pkg::kst_tok_t         tail;
  logic [kst_pkg::CNT_W-1:0] used_q, used_d;
  logic                      out_valid_q, out_valid_d;
  kst_pkg::kst_rsp_t         out_q, out_d;
  logic [31:0]               slot_wide, used_wide;

  assign in_stall_o = busy_q;
  assign in_xfer    = in_valid_i && !busy_q;
  assign out_xfer   = out_valid_q && !out_stall_i;

  // Entry register: holds the token, which then moves to cell 0.
  always_comb begin
    head_d        = '0;
    head_d.active = in_xfer;
    head_d.req    = in_data_i.req_type;
    head_d.key    = in_data_i.key;
    head_d.mask   = in_data_i.event_mask;
  end

  assign chain[0] = head_q;

  for (genvar g = 0; g < D; g++) begin : g_cell
    kst_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .idx_i (kst_pkg::IDX_W'(g)),
      .tok_i (chain[g]),
      .tok_o (chain[g+1])
    );
  end

  assign tail = chain[D];

  // Response formation and high-water update when the token leaves the chain.
  always_comb begin
    used_d      = used_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    busy_d      = busy_q;
    slot_wide   = 32'(tail.slot);
    used_wide   = 32'(used_q);

    if (out_xfer) begin
      out_valid_d = 1'b0;
      busy_d      = 1'b0;
    end
    if (in_xfer) begin
      busy_d = 1'b1;
    end

    if (tail.active) begin
      if (tail.hit && tail.req == kst_pkg::REQ_ADD &&
          kst_pkg::CNT_W'(tail.slot) == used_q) begin
        used_d = used_q + kst_pkg::CNT_W'(1);
      end
      used_wide   = 32'(used_d);
      out_valid_d = 1'b1;
      if (tail.hit) begin
        out_d.status     = kst_pkg::ST_OK;
        out_d.slot_index = slot_wide[3:0];
        out_d.found_mask = tail.fmask;
      end else begin
        out_d.status     = (tail.req == kst_pkg::REQ_ADD) ? kst_pkg::ST_FULL
                                                          : kst_pkg::ST_NOT_FOUND;
        out_d.slot_index = '0;
        out_d.found_mask = '0;
      end
      out_d.high_water = used_wide[4:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      head_q      <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      head_q      <= head_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire
